### rtl/core/usd_pkg.sv
// Package for the utilization scaling decision core: register map, request codes, helpers.
package usd_pkg;

    // Configuration port geometry
    localparam int unsigned APB_ADDR_W = 5;
    localparam int unsigned APB_DATA_W = 32;

    // Field widths
    localparam int unsigned UTIL_W   = 18;
    localparam int unsigned POLLS_W  = 16;
    localparam int unsigned CNT_W    = 8;
    localparam int unsigned STEP_W   = 4;
    localparam int unsigned MULT_W   = 8;
    localparam int unsigned PROD_W   = UTIL_W + MULT_W;   // spread * multiplier
    localparam int unsigned CMP_W    = PROD_W + 1;        // falling-trend compare width

    // Register indexes (byte address = 4 * index)
    typedef enum logic [2:0] {
        REG_HARD_UP_LEVEL    = 3'd0,
        REG_SOFT_UP_LEVEL    = 3'd1,
        REG_HARD_DOWN_LEVEL  = 3'd2,
        REG_SOFT_DOWN_LEVEL  = 3'd3,
        REG_COUNT_LIMIT      = 3'd4,
        REG_HARD_STEP        = 3'd5,
        REG_TREND_STEP       = 3'd6,
        REG_DOWN_SPREAD_MULT = 3'd7
    } t_reg_idx;

    // Reset values of the registers
    localparam logic [UTIL_W-1:0] RST_HARD_UP_LEVEL   = 18'd58982;
    localparam logic [UTIL_W-1:0] RST_SOFT_UP_LEVEL   = 18'd52429;
    localparam logic [UTIL_W-1:0] RST_HARD_DOWN_LEVEL = 18'd19661;
    localparam logic [UTIL_W-1:0] RST_SOFT_DOWN_LEVEL = 18'd32768;
    localparam logic [CNT_W-1:0]  RST_COUNT_LIMIT     = 8'd10;
    localparam logic [STEP_W-1:0] RST_HARD_STEP       = 4'd5;
    localparam logic [STEP_W-1:0] RST_TREND_STEP      = 4'd2;
    localparam logic [MULT_W-1:0] RST_DOWN_SPREAD_MULT = 8'd16;

    // Scale request codes
    typedef enum logic [1:0] {
        SCALE_NONE = 2'd0,
        SCALE_UP   = 2'd1,
        SCALE_DOWN = 2'd2
    } t_scale_req;

    // Counter add that saturates at the counter's full scale
    function automatic logic [CNT_W-1:0] sat_add(input logic [CNT_W-1:0] cnt,
                                                 input logic [STEP_W-1:0] inc);
        logic [CNT_W:0] sum;
        sum = {1'b0, cnt} + {{(CNT_W + 1 - STEP_W){1'b0}}, inc};
        if (sum[CNT_W]) begin
            return {CNT_W{1'b1}};
        end
        return sum[CNT_W-1:0];
    endfunction

endpackage

### rtl/core/utilization_scaling_decision_core.sv
// Top level of the utilization scaling decision core: trend flags, hysteresis counters, requests.
//
//  channel  | direction | handshake                 | payload
//  ---------+-----------+---------------------------+------------------------------------------
//  in       | input     | i_in_valid / o_in_ready   | weighted_util, simple_util, util_spread,
//           |           |                           | empty_polls
//  out      | output    | o_out_valid / i_out_ready | scale_request, rising_trend,
//           |           |                           | falling_trend, go_minimum
//  apb      | input     | psel, penable, pwrite     | paddr, pwdata, prdata (pready tied high)
//
// One transaction per cycle sustained while the output is ready; an accepted input passes through
// the input register, then combinational compare/multiply/counter logic, into the result register,
// and the trend flags and counters update with the result register, so items chain without bubbles.
// A stalled output holds its result while the input register still takes one more transaction.
// Reset (synchronous, active low) clears flags, counters, valids and restores register defaults.
module utilization_scaling_decision_core #(
    parameter int unsigned EMPTY_LIMIT = 10
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    // input channel
    input  logic                                i_in_valid,
    output logic                                o_in_ready,
    input  logic [usd_pkg::UTIL_W-1:0]          i_weighted_util,
    input  logic [usd_pkg::UTIL_W-1:0]          i_simple_util,
    input  logic [usd_pkg::UTIL_W-1:0]          i_util_spread,
    input  logic [usd_pkg::POLLS_W-1:0]         i_empty_polls,
    // output channel
    output logic                                o_out_valid,
    input  logic                                i_out_ready,
    output logic [1:0]                          o_scale_request,
    output logic                                o_rising_trend,
    output logic                                o_falling_trend,
    output logic                                o_go_minimum,
    // configuration port
    input  logic                                psel,
    input  logic                                penable,
    input  logic                                pwrite,
    input  logic [usd_pkg::APB_ADDR_W-1:0]      paddr,
    input  logic [usd_pkg::APB_DATA_W-1:0]      pwdata,
    output logic [usd_pkg::APB_DATA_W-1:0]      prdata,
    output logic                                pready
);

    localparam int unsigned UW = usd_pkg::UTIL_W;
    localparam int unsigned CW = usd_pkg::CNT_W;
    localparam int unsigned PW = usd_pkg::POLLS_W;

    // Configuration registers
    logic [UW-1:0]                 r_hard_up_level;
    logic [UW-1:0]                 r_soft_up_level;
    logic [UW-1:0]                 r_hard_down_level;
    logic [UW-1:0]                 r_soft_down_level;
    logic [CW-1:0]                 r_count_limit;
    logic [usd_pkg::STEP_W-1:0]    r_hard_step;
    logic [usd_pkg::STEP_W-1:0]    r_trend_step;
    logic [usd_pkg::MULT_W-1:0]    r_down_spread_mult;

    // Input register
    logic                          r_in_valid;
    logic [UW-1:0]                 r_w;
    logic [UW-1:0]                 r_s;
    logic [UW-1:0]                 r_sp;
    logic [PW-1:0]                 r_polls;

    // Decision state
    logic [CW-1:0]                 r_up_cnt;
    logic [CW-1:0]                 r_down_cnt;
    logic                          r_up_flag;
    logic                          r_down_flag;

    // Result register
    logic                          r_out_valid;
    usd_pkg::t_scale_req           r_out_req;
    logic                          r_out_rise;
    logic                          r_out_fall;
    logic                          r_out_min;

    // Next values
    logic [CW-1:0]                 n_up_cnt;
    logic [CW-1:0]                 n_down_cnt;
    logic                          n_up_flag;
    logic                          n_down_flag;
    usd_pkg::t_scale_req           n_req;
    logic                          n_min;

    logic                          cfg_wr;
    logic                          advance;
    logic                          rise;
    logic                          fall;
    logic [UW:0]                   rise_rhs;
    logic [usd_pkg::PROD_W-1:0]    spread_prod;
    logic [usd_pkg::CMP_W-1:0]     fall_lhs;
    logic [usd_pkg::CMP_W-1:0]     fall_rhs;
    logic [CW-1:0]                 up_sum;
    logic [CW-1:0]                 down_sum;

    // Handshake: the input register refills whenever it is empty or its content moves on
    assign advance     = r_in_valid && (!r_out_valid || i_out_ready);
    assign o_in_ready  = !r_in_valid || advance;
    assign o_out_valid = r_out_valid;

    assign o_scale_request = r_out_req;
    assign o_rising_trend  = r_out_rise;
    assign o_falling_trend = r_out_fall;
    assign o_go_minimum    = r_out_min;

    // APB register file
    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && pready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_hard_up_level    <= usd_pkg::RST_HARD_UP_LEVEL;
            r_soft_up_level    <= usd_pkg::RST_SOFT_UP_LEVEL;
            r_hard_down_level  <= usd_pkg::RST_HARD_DOWN_LEVEL;
            r_soft_down_level  <= usd_pkg::RST_SOFT_DOWN_LEVEL;
            r_count_limit      <= usd_pkg::RST_COUNT_LIMIT;
            r_hard_step        <= usd_pkg::RST_HARD_STEP;
            r_trend_step       <= usd_pkg::RST_TREND_STEP;
            r_down_spread_mult <= usd_pkg::RST_DOWN_SPREAD_MULT;
        end else if (cfg_wr) begin
            case (usd_pkg::t_reg_idx'(paddr[usd_pkg::APB_ADDR_W-1:2]))
                usd_pkg::REG_HARD_UP_LEVEL:    r_hard_up_level    <= pwdata[UW-1:0];
                usd_pkg::REG_SOFT_UP_LEVEL:    r_soft_up_level    <= pwdata[UW-1:0];
                usd_pkg::REG_HARD_DOWN_LEVEL:  r_hard_down_level  <= pwdata[UW-1:0];
                usd_pkg::REG_SOFT_DOWN_LEVEL:  r_soft_down_level  <= pwdata[UW-1:0];
                usd_pkg::REG_COUNT_LIMIT:      r_count_limit      <= pwdata[CW-1:0];
                usd_pkg::REG_HARD_STEP:        r_hard_step        <= pwdata[usd_pkg::STEP_W-1:0];
                usd_pkg::REG_TREND_STEP:       r_trend_step       <= pwdata[usd_pkg::STEP_W-1:0];
                usd_pkg::REG_DOWN_SPREAD_MULT: r_down_spread_mult <= pwdata[usd_pkg::MULT_W-1:0];
                default: begin
                end
            endcase
        end
    end

    // Register readback
    always_comb begin
        prdata = '0;
        case (usd_pkg::t_reg_idx'(paddr[usd_pkg::APB_ADDR_W-1:2]))
            usd_pkg::REG_HARD_UP_LEVEL:    prdata[UW-1:0] = r_hard_up_level;
            usd_pkg::REG_SOFT_UP_LEVEL:    prdata[UW-1:0] = r_soft_up_level;
            usd_pkg::REG_HARD_DOWN_LEVEL:  prdata[UW-1:0] = r_hard_down_level;
            usd_pkg::REG_SOFT_DOWN_LEVEL:  prdata[UW-1:0] = r_soft_down_level;
            usd_pkg::REG_COUNT_LIMIT:      prdata[CW-1:0] = r_count_limit;
            usd_pkg::REG_HARD_STEP:        prdata[usd_pkg::STEP_W-1:0] = r_hard_step;
            usd_pkg::REG_TREND_STEP:       prdata[usd_pkg::STEP_W-1:0] = r_trend_step;
            usd_pkg::REG_DOWN_SPREAD_MULT: prdata[usd_pkg::MULT_W-1:0] = r_down_spread_mult;
            default:                       prdata = '0;
        endcase
    end

    // Input register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (o_in_ready) begin
            r_in_valid <= i_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_in_ready && i_in_valid) begin
            r_w     <= i_weighted_util;
            r_s     <= i_simple_util;
            r_sp    <= i_util_spread;
            r_polls <= i_empty_polls;
        end
    end

    // Trend tests: rising w > s + sp; falling 16w + sp*mult < 16s (same as the signed form)
    always_comb begin
        rise_rhs    = {1'b0, r_s} + {1'b0, r_sp};
        rise        = {1'b0, r_w} > rise_rhs;
        spread_prod = usd_pkg::PROD_W'(r_sp) * usd_pkg::PROD_W'(r_down_spread_mult);
        fall_lhs    = {{(usd_pkg::CMP_W - UW - 4){1'b0}}, r_w, 4'b0000}
                      + {1'b0, spread_prod};
        fall_rhs    = {{(usd_pkg::CMP_W - UW - 4){1'b0}}, r_s, 4'b0000};
        fall        = fall_lhs < fall_rhs;

        // falling test is checked first and wins
        if (fall) begin
            n_up_flag   = 1'b0;
            n_down_flag = 1'b1;
        end else if (rise) begin
            n_up_flag   = 1'b1;
            n_down_flag = 1'b0;
        end else begin
            n_up_flag   = r_up_flag;
            n_down_flag = r_down_flag;
        end
    end

    // Hysteresis bands and requests
    always_comb begin
        n_up_cnt   = r_up_cnt;
        n_down_cnt = r_down_cnt;
        n_req      = usd_pkg::SCALE_NONE;
        up_sum     = '0;
        down_sum   = '0;
        if (r_w > r_hard_up_level) begin
            up_sum     = usd_pkg::sat_add(r_up_cnt, r_hard_step);
            n_down_cnt = '0;
            n_up_cnt   = up_sum;
            if (up_sum > r_count_limit) begin
                n_req    = usd_pkg::SCALE_UP;
                n_up_cnt = '0;
            end
        end else if (r_w > r_soft_up_level) begin
            up_sum     = usd_pkg::sat_add(r_up_cnt,
                             n_up_flag ? r_trend_step : usd_pkg::STEP_W'(1));
            n_down_cnt = '0;
            n_up_cnt   = up_sum;
            if (up_sum >= r_count_limit) begin
                n_req    = usd_pkg::SCALE_UP;
                n_up_cnt = '0;
            end
        end else if (r_w < r_hard_down_level) begin
            down_sum   = usd_pkg::sat_add(r_down_cnt, r_hard_step);
            n_up_cnt   = '0;
            n_down_cnt = down_sum;
            if (down_sum > r_count_limit) begin
                n_req      = usd_pkg::SCALE_DOWN;
                n_down_cnt = '0;
            end
        end else if (r_w < r_soft_down_level) begin
            down_sum   = usd_pkg::sat_add(r_down_cnt,
                             n_down_flag ? r_trend_step : usd_pkg::STEP_W'(1));
            n_up_cnt   = '0;
            n_down_cnt = down_sum;
            if (down_sum > r_count_limit) begin
                n_req      = usd_pkg::SCALE_DOWN;
                n_down_cnt = '0;
            end
        end
        n_min = r_polls > PW'(EMPTY_LIMIT);
    end

    // Decision state and result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_up_cnt    <= '0;
            r_down_cnt  <= '0;
            r_up_flag   <= 1'b0;
            r_down_flag <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (advance) begin
                r_up_cnt    <= n_up_cnt;
                r_down_cnt  <= n_down_cnt;
                r_up_flag   <= n_up_flag;
                r_down_flag <= n_down_flag;
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (advance) begin
            r_out_req  <= n_req;
            r_out_rise <= n_up_flag;
            r_out_fall <= n_down_flag;
            r_out_min  <= n_min;
        end
    end

`ifndef NO_ASSERTIONS
    // trend flags are mutually exclusive
    a_flags_excl: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(r_up_flag && r_down_flag))
        else $error("both trend flags set");

    // a fresh up request leaves both counters cleared
    a_up_clears: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        advance && n_req == usd_pkg::SCALE_UP |=> r_up_cnt == '0 && r_down_cnt == '0)
        else $error("counters not cleared after scale-up request");

    // a fresh down request leaves both counters cleared
    a_down_clears: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        advance && n_req == usd_pkg::SCALE_DOWN |=> r_up_cnt == '0 && r_down_cnt == '0)
        else $error("counters not cleared after scale-down request");

    // the reported flags match the state they came from
    a_flags_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        advance |=> r_out_rise == r_up_flag && r_out_fall == r_down_flag)
        else $error("result flags differ from trend state");

    // an empty output never blocks the input side
    a_no_block: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !r_out_valid |-> o_in_ready)
        else $error("input stalled with empty result register");
`endif

endmodule
